### design/gcide_pkg.sv
`default_nettype none

package gcide_pkg;

    // default size of the original buffer in bytes
    localparam int unsigned DEFAULT_ORIGINAL_DEPTH = 1024;

    // fixed widths of the op fields
    localparam int unsigned COPY_POS_W = 10;
    localparam int unsigned COPY_LEN_W = 11;

    typedef enum logic
    {
        FUNC_LOAD   = 1'b0,
        FUNC_ENCODE = 1'b1
    } func_t;

    typedef enum logic
    {
        OP_COPY   = 1'b0,
        OP_INSERT = 1'b1
    } op_kind_t;

    typedef struct packed
    {
        func_t      func;
        logic [7:0] data_byte;
        logic       last_of_buffer;
    } item_t;

    typedef struct packed
    {
        op_kind_t              op_kind;
        logic [COPY_POS_W-1:0] copy_position;
        logic [COPY_LEN_W-1:0] copy_length;
        logic [7:0]            insert_byte;
        logic                  last_op;
    } op_t;

    // ops produced by one item, slot 0 first
    typedef struct packed
    {
        logic [1:0]    count;
        op_t [1:0]     ops;
    } op_push_t;

endpackage

`default_nettype wire

### design/gcide_ffs.sv
`default_nettype none

// find-first-set as a balanced tree of (any, index) pairs
module gcide_ffs #(
    parameter int unsigned N = gcide_pkg::DEFAULT_ORIGINAL_DEPTH
) (
    input  wire logic [N-1:0]         vec,
    output      logic                 hit_any,
    output      logic [$clog2(N)-1:0] hit_index
);
    import gcide_pkg::*;

    localparam int unsigned LEVELS = $clog2(N);
    localparam int unsigned PAD    = 1 << LEVELS;

    logic              node_any [1:2*PAD-1];
    logic [LEVELS-1:0] node_idx [1:2*PAD-1];

    genvar k;
    genvar i;

    generate
        for (k = 0; k < PAD; k++)
        begin : g_leaf
            if (k < N)
            begin : g_real
                assign node_any[PAD+k] = vec[k];
            end
            else
            begin : g_pad
                assign node_any[PAD+k] = 1'b0;
            end
            assign node_idx[PAD+k] = LEVELS'(k);
        end

        for (i = 1; i < PAD; i++)
        begin : g_node
            assign node_any[i] = node_any[2*i] | node_any[2*i+1];
            assign node_idx[i] = node_any[2*i] ? node_idx[2*i] : node_idx[2*i+1];
        end
    endgenerate

    assign hit_any   = node_any[1];
    assign hit_index = node_idx[1];

endmodule

`default_nettype wire

### design/gcide_core.sv
`default_nettype none

// original store, candidate vector and op formation for one item
module gcide_core #(
    parameter int unsigned ORIGINAL_DEPTH = gcide_pkg::DEFAULT_ORIGINAL_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire gcide_pkg::item_t   item,
    output      gcide_pkg::op_push_t push
);
    import gcide_pkg::*;

    localparam int unsigned POS_W = $clog2(ORIGINAL_DEPTH);
    localparam int unsigned LEN_W = $clog2(ORIGINAL_DEPTH + 1);

    // original bytes, one compare per entry
    logic [7:0]                store_reg [ORIGINAL_DEPTH];
    logic [LEN_W-1:0]          orig_len_reg, orig_len_next;
    logic                      complete_reg, complete_next;
    // live_reg[q]: a candidate compares its next byte at offset q
    logic [ORIGINAL_DEPTH-1:0] live_reg, live_next;
    logic [LEN_W-1:0]          ml_reg, ml_next;
    logic [POS_W-1:0]          best_reg, best_next;

    logic [ORIGINAL_DEPTH-1:0] hit_all;
    logic [ORIGINAL_DEPTH-1:0] hit_ext;
    logic                      all_any, ext_any;
    logic [POS_W-1:0]          all_first, ext_first;

    logic             ml_zero;
    logic             is_load;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] ext_len;
    logic [POS_W-1:0] ext_pos;
    logic             store_we;
    logic [POS_W-1:0] store_addr;
    logic             has_pend, has_sec;
    op_t              pend_op, sec_op;

    function automatic op_t make_copy(input logic [POS_W-1:0] pos,
                                      input logic [LEN_W-1:0] len,
                                      input logic last);
        op_t o;
        o.op_kind       = OP_COPY;
        o.copy_position = COPY_POS_W'(pos);
        o.copy_length   = COPY_LEN_W'(len);
        o.insert_byte   = '0;
        o.last_op       = last;
        return o;
    endfunction

    function automatic op_t make_insert(input logic [7:0] b, input logic last);
        op_t o;
        o.op_kind       = OP_INSERT;
        o.copy_position = '0;
        o.copy_length   = '0;
        o.insert_byte   = b;
        o.last_op       = last;
        return o;
    endfunction

    assign ml_zero = (ml_reg == '0);
    assign is_load = (item.func == FUNC_LOAD);

    genvar q;
    generate
        for (q = 0; q < ORIGINAL_DEPTH; q++)
        begin : g_cmp
            logic eq;
            assign eq         = (store_reg[q] == item.data_byte) && (LEN_W'(q) < orig_len_reg);
            assign hit_all[q] = eq;
            assign hit_ext[q] = eq & (ml_zero | live_reg[q]);
        end
    endgenerate

    gcide_ffs #(
        .N (ORIGINAL_DEPTH)
    ) u_ffs_ext (
        .vec       (hit_ext),
        .hit_any   (ext_any),
        .hit_index (ext_first)
    );

    gcide_ffs #(
        .N (ORIGINAL_DEPTH)
    ) u_ffs_all (
        .vec       (hit_all),
        .hit_any   (all_any),
        .hit_index (all_first)
    );

    assign eff_len    = complete_reg ? '0 : orig_len_reg;
    assign ext_len    = ml_reg + LEN_W'(1);
    // all survivors share one length, so earliest end gives earliest start
    assign ext_pos    = ext_first - ml_reg[POS_W-1:0];
    assign store_we   = fire && is_load && (eff_len < LEN_W'(ORIGINAL_DEPTH));
    assign store_addr = eff_len[POS_W-1:0];

    // pending copy closed by a breaking byte
    assign has_pend = !ext_any && !ml_zero;
    assign pend_op  = make_copy(best_reg, ml_reg, 1'b0);

    always_comb
    begin
        if (ext_any)
        begin
            sec_op  = make_copy(ext_pos, ext_len, 1'b1);
            has_sec = item.last_of_buffer;
        end
        else if (all_any)
        begin
            sec_op  = make_copy(all_first, LEN_W'(1), 1'b1);
            has_sec = item.last_of_buffer;
        end
        else
        begin
            sec_op  = make_insert(item.data_byte, item.last_of_buffer);
            has_sec = 1'b1;
        end
    end

    always_comb
    begin
        push.ops[0] = has_pend ? pend_op : sec_op;
        push.ops[1] = sec_op;
        if (fire && !is_load)
        begin
            push.count = {1'b0, has_pend} + {1'b0, has_sec};
        end
        else
        begin
            push.count = '0;
        end
    end

    always_comb
    begin
        orig_len_next = orig_len_reg;
        complete_next = complete_reg;
        live_next     = live_reg;
        ml_next       = ml_reg;
        best_next     = best_reg;
        if (fire)
        begin
            if (is_load)
            begin
                if (complete_reg)
                begin
                    ml_next   = '0;
                    best_next = '0;
                end
                if (eff_len < LEN_W'(ORIGINAL_DEPTH))
                begin
                    orig_len_next = eff_len + LEN_W'(1);
                end
                else
                begin
                    orig_len_next = eff_len;
                end
                complete_next = item.last_of_buffer;
            end
            else if (ext_any)
            begin
                live_next = {hit_ext[ORIGINAL_DEPTH-2:0], 1'b0};
                ml_next   = item.last_of_buffer ? '0 : ext_len;
                best_next = item.last_of_buffer ? '0 : ext_pos;
            end
            else if (all_any)
            begin
                live_next = {hit_all[ORIGINAL_DEPTH-2:0], 1'b0};
                ml_next   = item.last_of_buffer ? '0 : LEN_W'(1);
                best_next = item.last_of_buffer ? '0 : all_first;
            end
            else
            begin
                ml_next   = '0;
                best_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[store_addr] <= item.data_byte;
        end
        live_reg <= live_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orig_len_reg <= '0;
            complete_reg <= 1'b0;
            ml_reg       <= '0;
            best_reg     <= '0;
        end
        else
        begin
            orig_len_reg <= orig_len_next;
            complete_reg <= complete_next;
            ml_reg       <= ml_next;
            best_reg     <= best_next;
        end
    end

    a_ml_within_orig: assert property (@(posedge clk) disable iff (!rst_n)
        ml_reg <= orig_len_reg)
        else $error("pending match longer than original");

    a_len_within_depth: assert property (@(posedge clk) disable iff (!rst_n)
        orig_len_reg <= LEN_W'(ORIGINAL_DEPTH))
        else $error("original length past capacity");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.ops[0].op_kind == OP_COPY && !push.ops[0].last_op)
        else $error("two ops without a leading non-final copy");

endmodule

`default_nettype wire

### design/gcide_fifo.sv
`default_nettype none

// small op queue, takes up to two ops a cycle and hands out one unless op_stall is high
module gcide_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gcide_pkg::op_push_t push,
    output      logic                room,
    output      logic                op_valid,
    input  wire logic                op_stall,
    output      gcide_pkg::op_t      op
);
    import gcide_pkg::*;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    op_t              entries_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign op_valid = (count_reg != '0);
    assign op       = entries_reg[rd_ptr_reg];
    assign pop      = op_valid && !op_stall;
    // two free slots so a whole item's ops always fit
    assign room     = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push.ops[0];
        end
        if (push.count == 2'd2)
        begin
            entries_reg[PTR_W'(wr_ptr_reg + 1'b1)] <= push.ops[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> ({1'b0, count_reg} + (CNT_W+1)'(push.count))
                               <= (CNT_W+1)'(FIFO_DEPTH))
        else $error("op queue overflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != CNT_W'(FIFO_DEPTH) |-> PTR_W'(wr_ptr_reg - rd_ptr_reg) == PTR_W'(count_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

### design/greedy_copy_insert_delta_encoder_top.sv
`default_nettype none

// an accepted item waits in the input register; its ops are written to the op queue when it fires
// throughput: one item per cycle; an item gives zero, one or two ops, and the op queue
//   drains one op per unstalled cycle, so an encode item holds while under two slots are free
// reset: control state and the op queue clear at once; original bytes and the
//   candidate vector are left as they are, no clearing pass is run
module greedy_copy_insert_delta_encoder_top #(
    parameter int unsigned ORIGINAL_DEPTH = gcide_pkg::DEFAULT_ORIGINAL_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // item channel: one beat is one original or modified byte
    input  wire logic             item_valid,
    output      logic             item_stall,
    input  wire gcide_pkg::item_t item,
    // op channel: one beat is one copy or insert op
    output      logic             op_valid,
    input  wire logic             op_stall,
    output      gcide_pkg::op_t   op
);
    import gcide_pkg::*;

    // input register: the beat waiting for the match stage
    item_t    item_reg;
    logic     item_valid_reg, item_valid_next;
    logic     room;
    logic     fire;
    logic     accept;
    op_push_t push;

    // loads make no ops and never wait for queue space
    assign fire       = item_valid_reg && ((item_reg.func == FUNC_LOAD) || room);
    assign item_stall = item_valid_reg && !fire;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // match stage: compares the byte against every stored original byte
    gcide_core #(
        .ORIGINAL_DEPTH (ORIGINAL_DEPTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .push  (push)
    );

    // result register: op queue in front of the op channel
    gcide_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .op_valid (op_valid),
        .op_stall (op_stall),
        .op       (op)
    );

endmodule

`default_nettype wire
